FILE: hdl/pgrad_pkg.sv
package pgrad_pkg;

    localparam int GRID_DIM_MAX_DEF = 32;

    localparam int POT_W   = 32;
    localparam int FIELD_W = 48;
    localparam int SIZE_W  = 6;
    localparam int POS_W   = 5;
    localparam int SCALE_W = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [SIZE_W-1:0]  SIZE_RESET  = 6'd32;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd65536;

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Z = 3'd5;

    localparam logic KIND_STORE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

endpackage

FILE: hdl/pgrad_ram.sv
module pgrad_ram #(
    parameter int WIDTH = pgrad_pkg::POT_W,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_array[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_array[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/potential_gradient_3d.sv
// Electric field E = -grad(phi) on a 3D grid of signed Q16.16 potentials held in a single-port
// memory of GRID_DIM_MAX^3 words. A store beat writes one potential and gives no result. A query
// beat gives one result: at an interior point central differences on all axes, at a point on
// exactly one face the one-sided (-3,4,-1) stencil on that axis, each difference multiplied by
// the axis scale, shifted right by 16 (toward minus infinity) and saturated to 48 bits. Edge,
// corner and out-of-range points give written = 0 and zero fields. A query at a valid point
// holds the input through seven reads on the one memory port, a drain state that takes in
// the last word, then the MLO, MHI and SUM states per axis on one shared 36x17 multiplier and a
// done state that loads the output register once it is free; any other query goes straight to the
// done state. The memory is not cleared; a query must only touch points that were stored.
module potential_gradient_3d #(
    parameter int GRID_DIM_MAX = pgrad_pkg::GRID_DIM_MAX_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,

    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [pgrad_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [pgrad_pkg::SCALE_W-1:0]           cfg_data,

    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic                                    kind,
    input  logic [pgrad_pkg::POS_W-1:0]             pos_x,
    input  logic [pgrad_pkg::POS_W-1:0]             pos_y,
    input  logic [pgrad_pkg::POS_W-1:0]             pos_z,
    input  logic signed [pgrad_pkg::POT_W-1:0]      potential,

    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [pgrad_pkg::FIELD_W-1:0]    field_x,
    output logic signed [pgrad_pkg::FIELD_W-1:0]    field_y,
    output logic signed [pgrad_pkg::FIELD_W-1:0]    field_z,
    output logic                                    written
);

    localparam int DEPTH    = GRID_DIM_MAX * GRID_DIM_MAX * GRID_DIM_MAX;
    localparam int AW       = $clog2(DEPTH);
    localparam int SIZE_LIM = (GRID_DIM_MAX > 63) ? 63 : GRID_DIM_MAX;
    localparam logic [pgrad_pkg::SIZE_W-1:0] SIZE_LIM6 = 6'(SIZE_LIM);
    localparam int GW = 36;
    localparam int MW = 17;
    localparam int PW = GW + MW;
    localparam int LW = PW - 16;
    localparam int SW = PW + 1;
    localparam int FW = pgrad_pkg::FIELD_W;
    localparam logic signed [FW-1:0] SAT_HI = {1'b0, {(FW-1){1'b1}}};
    localparam logic signed [FW-1:0] SAT_LO = {1'b1, {(FW-1){1'b0}}};

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_READ  = 7'b0000010,
        S_DRAIN = 7'b0000100,
        S_MLO   = 7'b0001000,
        S_MHI   = 7'b0010000,
        S_SUM   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    typedef enum logic [1:0] {
        CLS_INT  = 2'd0,
        CLS_LOW  = 2'd1,
        CLS_HIGH = 2'd2
    } cls_t;

    typedef enum logic [1:0] {
        AX_X = 2'd0,
        AX_Y = 2'd1,
        AX_Z = 2'd2
    } axis_t;

    typedef struct packed {
        logic in_range;
        logic low;
        logic high;
    } pos_class_t;

    function automatic logic [pgrad_pkg::SIZE_W-1:0] clamp_size(
        input logic [pgrad_pkg::SIZE_W-1:0] s
    );
        logic [pgrad_pkg::SIZE_W-1:0] r;
        begin
            r = s;
            if (s < 6'd3)
            begin
                r = 6'd3;
            end
            else if (s > SIZE_LIM6)
            begin
                r = SIZE_LIM6;
            end
            return r;
        end
    endfunction

    function automatic pos_class_t classify(
        input logic [pgrad_pkg::POS_W-1:0]  p,
        input logic [pgrad_pkg::SIZE_W-1:0] n
    );
        pos_class_t c;
        begin
            c.in_range = ({1'b0, p} < n);
            c.low      = (p == '0);
            c.high     = ({1'b0, p} == (n - 6'd1));
            return c;
        end
    endfunction

    function automatic cls_t to_cls(input pos_class_t c);
        cls_t r;
        begin
            r = CLS_INT;
            if (c.low)
            begin
                r = CLS_LOW;
            end
            else if (c.high)
            begin
                r = CLS_HIGH;
            end
            return r;
        end
    endfunction

    function automatic axis_t step_axis(input logic [2:0] s);
        axis_t a;
        begin
            unique case (s)
                3'd3, 3'd4: a = AX_Y;
                3'd5, 3'd6: a = AX_Z;
                default:    a = AX_X;
            endcase
            return a;
        end
    endfunction

    state_t state_reg, state_next;

    logic [pgrad_pkg::SIZE_W-1:0]  size_x_reg, size_y_reg, size_z_reg;
    logic [pgrad_pkg::SCALE_W-1:0] scale_x_reg, scale_y_reg, scale_z_reg;

    logic [pgrad_pkg::POS_W-1:0] px_reg, py_reg, pz_reg;
    cls_t                        cls_x_reg, cls_y_reg, cls_z_reg;
    axis_t                       face_axis_reg;
    logic                        has_face_reg;
    logic                        ok_reg;

    logic [2:0]  cnt_reg;
    logic        dv_reg;
    logic [2:0]  dstep_reg;
    logic [1:0]  ax_reg;

    logic signed [GW-1:0] g_reg [3];
    logic signed [PW-1:0] prod_reg;
    logic signed [LW-1:0] low_reg;
    logic signed [FW-1:0] res_reg [3];

    logic                 out_valid_reg;
    logic signed [FW-1:0] field_x_reg, field_y_reg, field_z_reg;
    logic                 written_reg;

    logic in_acc, store_acc, query_acc, out_load;
    pos_class_t qc_x, qc_y, qc_z;
    logic       q_ok;
    logic [1:0] q_faces;

    logic [pgrad_pkg::POT_W-1:0] ram_rdata;
    logic [AW-1:0]               ram_addr;
    logic                        ram_en, ram_we;
    logic                        store_in_grid;

    axis_t                 rd_axis;
    cls_t                  rd_cls;
    logic [5:0]            rd_off;
    logic [5:0]            rx6, ry6, rz6;
    logic [AW-1:0]         rd_addr, st_addr;

    axis_t                 dax;
    cls_t                  dcls;
    logic [1:0]            gidx;
    logic signed [GW-1:0]  dw, dw3, dterm, g_cur, g_upd;
    logic                  dsub, den;

    logic [pgrad_pkg::SCALE_W-1:0] scale_cur;
    logic signed [MW-1:0]          mul_b;
    logic signed [PW-1:0]          mul_p;
    logic signed [SW-1:0]          sum;
    logic signed [FW-1:0]          sat;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign store_acc = in_acc && (kind == pgrad_pkg::KIND_STORE);
    assign query_acc = in_acc && (kind == pgrad_pkg::KIND_QUERY);
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    assign qc_x = classify(pos_x, clamp_size(size_x_reg));
    assign qc_y = classify(pos_y, clamp_size(size_y_reg));
    assign qc_z = classify(pos_z, clamp_size(size_z_reg));
    assign q_faces = 2'((qc_x.low || qc_x.high)) + 2'((qc_y.low || qc_y.high))
                   + 2'((qc_z.low || qc_z.high));
    assign q_ok = qc_x.in_range && qc_y.in_range && qc_z.in_range && (q_faces <= 2'd1);

    always_comb
    begin
        rd_axis = step_axis(cnt_reg);
        unique case (rd_axis)
            AX_Y:    rd_cls = cls_y_reg;
            AX_Z:    rd_cls = cls_z_reg;
            default: rd_cls = cls_x_reg;
        endcase
        rd_off = 6'd0;
        if (cnt_reg != 3'd0)
        begin
            if (cnt_reg[0])
            begin
                rd_off = (rd_cls == CLS_LOW) ? 6'd1 : 6'h3F;
            end
            else
            begin
                unique case (rd_cls)
                    CLS_LOW:  rd_off = 6'd2;
                    CLS_HIGH: rd_off = 6'h3E;
                    default:  rd_off = 6'd1;
                endcase
            end
        end
        rx6 = {1'b0, px_reg} + ((cnt_reg != 3'd0 && rd_axis == AX_X) ? rd_off : 6'd0);
        ry6 = {1'b0, py_reg} + ((cnt_reg != 3'd0 && rd_axis == AX_Y) ? rd_off : 6'd0);
        rz6 = {1'b0, pz_reg} + ((cnt_reg != 3'd0 && rd_axis == AX_Z) ? rd_off : 6'd0);
    end

    assign rd_addr = AW'(32'(rx6) * GRID_DIM_MAX * GRID_DIM_MAX
                       + 32'(ry6) * GRID_DIM_MAX + 32'(rz6));
    assign st_addr = AW'(32'(pos_x) * GRID_DIM_MAX * GRID_DIM_MAX
                       + 32'(pos_y) * GRID_DIM_MAX + 32'(pos_z));

    assign store_in_grid = (32'(pos_x) < GRID_DIM_MAX) && (32'(pos_y) < GRID_DIM_MAX)
                         && (32'(pos_z) < GRID_DIM_MAX);
    assign ram_we   = store_acc && store_in_grid;
    assign ram_en   = ram_we || (state_reg == S_READ);
    assign ram_addr = (state_reg == S_IDLE) ? st_addr : rd_addr;

    pgrad_ram #(
        .WIDTH (pgrad_pkg::POT_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (potential),
        .rdata (ram_rdata)
    );

    // A returning word adds its stencil term to one axis; the centre word only at a face point.
    always_comb
    begin
        dax = (dstep_reg == 3'd0) ? face_axis_reg : step_axis(dstep_reg);
        unique case (dax)
            AX_Y:    dcls = cls_y_reg;
            AX_Z:    dcls = cls_z_reg;
            default: dcls = cls_x_reg;
        endcase
        dw  = GW'($signed(ram_rdata));
        dw3 = (dw <<< 1) + dw;
        den = dv_reg;
        dsub  = 1'b0;
        dterm = dw;
        if (dstep_reg == 3'd0)
        begin
            den   = dv_reg && has_face_reg;
            dterm = dw3;
            dsub  = (dcls == CLS_HIGH);
        end
        else if (dstep_reg[0])
        begin
            dterm = (dcls == CLS_INT) ? dw : (dw <<< 2);
            dsub  = (dcls == CLS_LOW);
        end
        else
        begin
            dsub = (dcls != CLS_LOW);
        end
        gidx  = dv_reg ? dax : ax_reg;
        g_cur = g_reg[gidx];
        g_upd = dsub ? (g_cur - dterm) : (g_cur + dterm);
    end

    always_comb
    begin
        unique case (ax_reg)
            AX_Y:    scale_cur = scale_y_reg;
            AX_Z:    scale_cur = scale_z_reg;
            default: scale_cur = scale_x_reg;
        endcase
        mul_b = (state_reg == S_MLO) ? $signed({1'b0, scale_cur[15:0]})
                                     : $signed({1'b0, scale_cur[31:16]});
        mul_p = g_cur * mul_b;
        sum   = SW'(prod_reg) + SW'(low_reg);
        if (sum[SW-1:FW-1] == {(SW-FW+1){sum[FW-1]}})
        begin
            sat = sum[FW-1:0];
        end
        else
        begin
            sat = sum[SW-1] ? SAT_LO : SAT_HI;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (query_acc)
                begin
                    state_next = q_ok ? S_READ : S_DONE;
                end
            end
            S_READ:
            begin
                if (cnt_reg == 3'd6)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: state_next = S_MLO;
            S_MLO:   state_next = S_MHI;
            S_MHI:   state_next = S_SUM;
            S_SUM:   state_next = (ax_reg == AX_Z) ? S_DONE : S_MLO;
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            size_x_reg    <= pgrad_pkg::SIZE_RESET;
            size_y_reg    <= pgrad_pkg::SIZE_RESET;
            size_z_reg    <= pgrad_pkg::SIZE_RESET;
            scale_x_reg   <= pgrad_pkg::SCALE_RESET;
            scale_y_reg   <= pgrad_pkg::SCALE_RESET;
            scale_z_reg   <= pgrad_pkg::SCALE_RESET;
            cnt_reg       <= '0;
            dv_reg        <= 1'b0;
            ax_reg        <= AX_X;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    pgrad_pkg::CFG_SIZE_X:  size_x_reg  <= cfg_data[pgrad_pkg::SIZE_W-1:0];
                    pgrad_pkg::CFG_SIZE_Y:  size_y_reg  <= cfg_data[pgrad_pkg::SIZE_W-1:0];
                    pgrad_pkg::CFG_SIZE_Z:  size_z_reg  <= cfg_data[pgrad_pkg::SIZE_W-1:0];
                    pgrad_pkg::CFG_SCALE_X: scale_x_reg <= cfg_data;
                    pgrad_pkg::CFG_SCALE_Y: scale_y_reg <= cfg_data;
                    pgrad_pkg::CFG_SCALE_Z: scale_z_reg <= cfg_data;
                    default: ;
                endcase
            end
            dv_reg <= (state_reg == S_READ);
            if (state_reg == S_READ)
            begin
                cnt_reg <= cnt_reg + 3'd1;
            end
            else
            begin
                cnt_reg <= '0;
            end
            if (state_reg == S_SUM)
            begin
                ax_reg <= ax_reg + 2'd1;
            end
            else if (state_reg == S_DRAIN)
            begin
                ax_reg <= AX_X;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dstep_reg <= cnt_reg;
        if (query_acc)
        begin
            px_reg        <= pos_x;
            py_reg        <= pos_y;
            pz_reg        <= pos_z;
            cls_x_reg     <= to_cls(qc_x);
            cls_y_reg     <= to_cls(qc_y);
            cls_z_reg     <= to_cls(qc_z);
            has_face_reg  <= (q_faces != 2'd0);
            face_axis_reg <= (qc_x.low || qc_x.high) ? AX_X
                           : ((qc_y.low || qc_y.high) ? AX_Y : AX_Z);
            ok_reg        <= q_ok;
            for (int i = 0; i < 3; i++)
            begin
                g_reg[i]   <= '0;
                res_reg[i] <= '0;
            end
        end
        if (den)
        begin
            g_reg[gidx] <= g_upd;
        end
        if (state_reg == S_MLO)
        begin
            prod_reg <= mul_p;
        end
        if (state_reg == S_MHI)
        begin
            prod_reg <= mul_p;
            low_reg  <= prod_reg[PW-1:16];
        end
        if (state_reg == S_SUM)
        begin
            res_reg[ax_reg] <= sat;
        end
        if (out_load)
        begin
            field_x_reg <= res_reg[0];
            field_y_reg <= res_reg[1];
            field_z_reg <= res_reg[2];
            written_reg <= ok_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign field_x   = field_x_reg;
    assign field_y   = field_y_reg;
    assign field_z   = field_z_reg;
    assign written   = written_reg;

`ifndef SYNTHESIS
    a_dv_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        dv_reg |-> (state_reg == S_READ || state_reg == S_DRAIN))
        else $error("memory data returned outside the read phase");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        query_acc |=> !in_ready)
        else $error("input taken again right after a query beat");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid)
        else $error("finished query did not reach the output register");

    a_unwritten_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !written) |-> (field_x == '0 && field_y == '0 && field_z == '0))
        else $error("nonzero field for a point without a stencil");
`endif

endmodule
